// File: src/edrm_pkg.sv
// Shared types and constants for the descriptor ring manager.
package edrm_pkg;

    localparam int DESC_COUNT_DEF = 4;
    localparam int MAX_RESULTS    = 10;
    localparam int CNT_W          = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int LEN_W          = 16;
    localparam int TX_LEN_W       = 11;
    localparam int ERR_W          = 5;
    localparam int IDX_OUT_W      = 6;
    localparam int CNT_OUT_W      = 16;

    localparam logic [10:0] MAX_LEN_RST   = 11'd1536;
    localparam logic [4:0]  SVC_LIMIT_RST = 5'd10;
    localparam logic [15:0] REFUSED_MAX   = 16'hffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FRAME_LENGTH = 1'b0,
        CFG_SERVICE_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_TX_SUBMIT  = 2'd0,
        CMD_TX_DONE    = 2'd1,
        CMD_RX_FRAME   = 2'd2,
        CMD_RX_SERVICE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_NO_FREE   = 3'd2,
        ST_NOTHING   = 3'd3,
        ST_NO_RX_BUF = 3'd4
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [IDX_OUT_W-1:0]  desc_index;
        logic [LEN_W-1:0]      frame_length;
        logic [CNT_OUT_W-1:0]  error_count;
        logic                  last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic             hold_valid;
        logic             out_free;
        logic             cur_owned;
        logic             cur_good;
        logic [CNT_W-1:0] limit;
    } t_dp_stat;

endpackage

// File: src/edrm_in_if.sv
// Input command channel.
interface edrm_in_if import edrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [LEN_W-1:0] length;
    logic             rx_last;
    logic [ERR_W-1:0] rx_errors;

    modport source (output valid, cmd, length, rx_last, rx_errors, input ready);
    modport sink   (input valid, cmd, length, rx_last, rx_errors, output ready);
endinterface

// File: src/edrm_out_if.sv
// Result channel.
interface edrm_out_if import edrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [IDX_OUT_W-1:0] desc_index;
    logic [LEN_W-1:0]     frame_length;
    logic [CNT_OUT_W-1:0] error_count;
    logic                 last;

    modport source (output valid, status, desc_index, frame_length, error_count, last,
                    input ready);
    modport sink   (input valid, status, desc_index, frame_length, error_count, last,
                    output ready);
endinterface

// File: src/edrm_ctrl.sv
// Controller state machine: command sequencing and receive service walk.
module edrm_ctrl import edrm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_cmd,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK_RD,
        S_WALK
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;
    logic             done_walk;
    logic             stall;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.hold_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign done_walk  = (r_cnt == i_stat.limit) || i_stat.cur_owned;
    assign stall      = i_stat.cur_good && i_stat.hold_valid && !i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.load = accept;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    if (t_cmd'(i_in_cmd) == CMD_RX_SERVICE) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_WALK_RD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (done_walk) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (!stall) begin
                    o_cmd.step = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_state    = S_WALK_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: src/edrm_datapath.sv
// Datapath: ring state, descriptor stores, config registers, result registers.
module edrm_datapath import edrm_pkg::*; #(
    parameter int DESC_COUNT = DESC_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_in_cmd,
    input  logic [LEN_W-1:0]      i_in_length,
    input  logic                  i_in_rx_last,
    input  logic [ERR_W-1:0]      i_in_rx_errors,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    edrm_out_if.source            o_result
);

    localparam int IW    = $clog2(DESC_COUNT);
    localparam int RX_W  = LEN_W + 1 + ERR_W;

    typedef logic [IW-1:0] t_idx;

    function automatic t_idx next_slot(input t_idx i);
        return (i == t_idx'(DESC_COUNT - 1)) ? '0 : t_idx'(i + 1'b1);
    endfunction

    // config
    logic [TX_LEN_W-1:0] r_max_len;
    logic [4:0]          r_svc_limit;

    // ring control
    logic [DESC_COUNT-1:0] r_tx_owned;
    logic [DESC_COUNT-1:0] r_rx_dma_owned;
    t_idx                  r_tx_sub, r_tx_cmp, r_rx_fill, r_rx_svc;
    logic [CNT_OUT_W-1:0]  r_refused, n_refused;

    // stores
    logic [TX_LEN_W-1:0] r_tx_mem [DESC_COUNT];
    logic [RX_W-1:0]     r_rx_mem [DESC_COUNT];
    logic [TX_LEN_W-1:0] r_tx_rd;
    logic [RX_W-1:0]     r_rx_rd;

    // latched transaction
    t_cmd             r_cmd;
    logic [LEN_W-1:0] r_len;
    logic             r_last;
    logic [ERR_W-1:0] r_err;

    // result staging
    logic    r_hold_valid;
    t_result r_hold, n_exec_res;
    logic    r_out_valid;
    t_result r_out;

    logic out_free;
    logic hold_xfer;
    logic push;
    logic cur_good;
    logic tx_wr, rx_wr;
    logic tx_sub_adv, tx_cmp_adv, rx_fill_adv;

    assign out_free  = !r_out_valid || o_result.ready;
    assign cur_good  = r_rx_rd[LEN_W] && (r_rx_rd[RX_W-1 -: ERR_W] == '0);
    assign hold_xfer = r_hold_valid && r_hold.last && out_free;
    assign push      = i_cmd.step && cur_good && r_hold_valid;

    assign o_stat.hold_valid = r_hold_valid;
    assign o_stat.out_free   = out_free;
    assign o_stat.cur_owned  = r_rx_dma_owned[r_rx_svc];
    assign o_stat.cur_good   = cur_good;
    assign o_stat.limit      = (r_svc_limit > 5'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
                                                                : r_svc_limit[CNT_W-1:0];

    // single-result commands
    always_comb begin
        n_refused   = r_refused;
        tx_wr       = 1'b0;
        rx_wr       = 1'b0;
        tx_sub_adv  = 1'b0;
        tx_cmp_adv  = 1'b0;
        rx_fill_adv = 1'b0;
        n_exec_res  = '0;
        n_exec_res.last = 1'b1;
        unique case (r_cmd)
            CMD_TX_SUBMIT: begin
                n_exec_res.desc_index = IDX_OUT_W'(r_tx_sub);
                if (r_len > LEN_W'(r_max_len)) begin
                    n_exec_res.status = ST_TOO_BIG;
                end else if (r_tx_owned[r_tx_sub]) begin
                    n_exec_res.status = ST_NO_FREE;
                    if (r_refused != REFUSED_MAX) begin
                        n_refused = r_refused + 1'b1;
                    end
                end else begin
                    n_exec_res.status       = ST_OK;
                    n_exec_res.frame_length = r_len;
                    tx_wr      = i_cmd.exec;
                    tx_sub_adv = i_cmd.exec;
                end
            end
            CMD_TX_DONE: begin
                n_exec_res.desc_index = IDX_OUT_W'(r_tx_cmp);
                if (!r_tx_owned[r_tx_cmp]) begin
                    n_exec_res.status = ST_NOTHING;
                end else begin
                    n_exec_res.status       = ST_OK;
                    n_exec_res.frame_length = LEN_W'(r_tx_rd);
                    tx_cmp_adv = i_cmd.exec;
                end
            end
            CMD_RX_FRAME: begin
                n_exec_res.desc_index = IDX_OUT_W'(r_rx_fill);
                if (!r_rx_dma_owned[r_rx_fill]) begin
                    n_exec_res.status = ST_NO_RX_BUF;
                end else begin
                    n_exec_res.status       = ST_OK;
                    n_exec_res.frame_length = r_len;
                    rx_wr       = i_cmd.exec;
                    rx_fill_adv = i_cmd.exec;
                end
            end
            CMD_RX_SERVICE: begin
                n_exec_res.status     = ST_NOTHING;
                n_exec_res.desc_index = IDX_OUT_W'(r_rx_svc);
            end
            default: n_exec_res.status = ST_NOTHING;
        endcase
        n_exec_res.error_count = n_refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RST;
            r_svc_limit <= SVC_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_FRAME_LENGTH: r_max_len   <= i_cfg_data;
                CFG_SERVICE_LIMIT:    r_svc_limit <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= t_cmd'(i_in_cmd);
            r_len  <= i_in_length;
            r_last <= i_in_rx_last;
            r_err  <= i_in_rx_errors;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_wr) begin
            r_tx_mem[r_tx_sub] <= r_len[TX_LEN_W-1:0];
        end
        r_tx_rd <= r_tx_mem[r_tx_cmp];
    end

    always_ff @(posedge i_clk) begin
        if (rx_wr) begin
            r_rx_mem[r_rx_fill] <= {r_err, r_last, r_len};
        end
        r_rx_rd <= r_rx_mem[r_rx_svc];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_owned     <= '0;
            r_rx_dma_owned <= '1;
            r_tx_sub       <= '0;
            r_tx_cmp       <= '0;
            r_rx_fill      <= '0;
            r_rx_svc       <= '0;
            r_refused      <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_refused <= n_refused;
            end
            if (tx_sub_adv) begin
                r_tx_owned[r_tx_sub] <= 1'b1;
                r_tx_sub             <= next_slot(r_tx_sub);
            end
            if (tx_cmp_adv) begin
                r_tx_owned[r_tx_cmp] <= 1'b0;
                r_tx_cmp             <= next_slot(r_tx_cmp);
            end
            if (rx_fill_adv) begin
                r_rx_dma_owned[r_rx_fill] <= 1'b0;
                r_rx_fill                 <= next_slot(r_rx_fill);
            end
            if (i_cmd.step) begin
                r_rx_dma_owned[r_rx_svc] <= 1'b1;
                r_rx_svc                 <= next_slot(r_rx_svc);
            end
        end
    end

    // hold stage: the newest result, released once known to be final or superseded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else begin
            priority if (i_cmd.exec) begin
                r_hold_valid <= 1'b1;
                r_hold       <= n_exec_res;
            end else if (i_cmd.step && cur_good) begin
                r_hold_valid       <= 1'b1;
                r_hold.status      <= ST_OK;
                r_hold.desc_index  <= IDX_OUT_W'(r_rx_svc);
                r_hold.frame_length <= r_rx_rd[LEN_W-1:0];
                r_hold.error_count <= r_refused;
                r_hold.last        <= 1'b0;
            end else if (i_cmd.finish) begin
                r_hold_valid <= 1'b1;
                r_hold.last  <= 1'b1;
                if (!r_hold_valid) begin
                    r_hold.status       <= ST_NOTHING;
                    r_hold.desc_index   <= IDX_OUT_W'(r_rx_svc);
                    r_hold.frame_length <= '0;
                    r_hold.error_count  <= r_refused;
                end
            end else begin
                if (hold_xfer) begin
                    r_hold_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (hold_xfer || push) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hold_xfer || push) begin
            r_out <= r_hold;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.desc_index   = r_out.desc_index;
    assign o_result.frame_length = r_out.frame_length;
    assign o_result.error_count  = r_out.error_count;
    assign o_result.last         = r_out.last;

endmodule

// File: src/eth_descriptor_ring_manager.sv
// Top level of the transmit/receive descriptor ring manager.
//
//  channel   dir  modport  payload
//  i_item    in   sink     cmd, length, rx_last, rx_errors
//  o_result  out  source   status, desc_index, frame_length, error_count, last
//  i_cfg_*   in   -        write enable, register index, 11-bit data
//
// Tx submit, tx done and rx frame: accepted, executed next cycle, result staged;
// the next transaction is taken only once the previous result has left the hold stage.
// Rx service: walks the receive ring until the service limit or a DMA-owned descriptor;
// each ring advance is followed by a wait state for the registered read of the store.
// Results wait in a hold stage and an output register; output stalls hold the walk.
// Synchronous active-low reset; descriptor stores are not cleared.
module eth_descriptor_ring_manager import edrm_pkg::*; #(
    parameter int DESC_COUNT = DESC_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    edrm_in_if.sink               i_item,
    edrm_out_if.source            o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    edrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_cmd   (i_item.cmd),
        .o_in_ready (i_item.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    edrm_datapath #(
        .DESC_COUNT (DESC_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_cmd       (i_item.cmd),
        .i_in_length    (i_item.length),
        .i_in_rx_last   (i_item.rx_last),
        .i_in_rx_errors (i_item.rx_errors),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result       (o_result)
    );

endmodule
